// ===== design/fcct_pkg.sv =====
package fcct_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam int unsigned MAP_DEPTH = 256;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned DCNT_W    = 9;
    localparam int unsigned OCNT_W    = 9;

    typedef enum logic [1:0] {
        OP_DATA      = 2'd0,
        OP_LAST      = 2'd1,
        OP_EMPTY_END = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_REJECT  = 2'd1,
        ST_CLEARED = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [7:0]        data_byte;
        logic [IDX_W-1:0]  frag_index;
        logic [31:0]       given_crc;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [31:0]       computed_crc;
        logic [OCNT_W-1:0] stored_count;
        logic              complete;
    } t_out_item;

    // Advance a reflected CRC-32 register by one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/fragment_crc_check_tracker_core.sv =====
// An item that ends a fragment or clears loads the check stage on acceptance, and its
// result moves on to the output register once that is free; a data byte yields none.
// Throughput: one item per cycle, set by the byte-wide CRC step and the one read and
// one write port of the presence memory. Stalls only back-pressure from the output.
// Reset (i_rst_n low, synchronous) restores the CRC to all ones, zeroes the counts
// and drops every presence valid bit at once; no clearing pass is needed.
module fragment_crc_check_tracker_core
    import fcct_pkg::*;
#(
    parameter int unsigned MAX_FRAGMENTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // Total count must hold MAX_FRAGMENTS + 1 (the saturation value).
    localparam int unsigned CNT_W = $clog2(MAX_FRAGMENTS + 2);
    // Common width for comparisons between the counters and the index.
    localparam int unsigned CMP_W = CNT_W + DCNT_W;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAGMENTS + 1);
    localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_FRAGMENTS);

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic in_fire;
    logic out_free;
    logic b_fire;
    logic b_load;

    logic r_b_valid;
    logic r_out_valid;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign b_fire     = r_b_valid && out_free;
    // Hold the input only while the check stage cannot drain.
    assign o_in_stall = r_b_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;
    // Every op except a plain data byte produces a result.
    assign b_load     = in_fire && (i_in.op != OP_DATA);

    // ---------------------------------------------------------------
    // Stage A: running CRC, one byte per item
    // ---------------------------------------------------------------
    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] a_crc_adv;
    logic [31:0] a_final;

    assign a_crc_adv = crc_byte(r_crc, i_in.data_byte);

    always_comb begin
        n_crc   = r_crc;
        a_final = ~r_crc;
        if (in_fire) begin
            case (i_in.op)
                OP_DATA: begin
                    n_crc = a_crc_adv;
                end
                OP_LAST: begin
                    a_final = ~a_crc_adv;
                    n_crc   = CRC_ONES;
                end
                default: begin
                    // Empty end finishes on the current register; it and a clear both restart it.
                    n_crc = CRC_ONES;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Presence memory: data bits in a synchronous array, one valid bit
    // per entry in flops so a clear drops every valid bit at once.
    // ---------------------------------------------------------------
    logic                 r_mem [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_vld;
    logic                 r_mem_rd;
    logic                 r_vld_rd;

    // Stage B payload
    t_op              r_b_op;
    logic [IDX_W-1:0] r_b_idx;
    logic [31:0]      r_b_crc;
    logic             r_b_match;
    logic             r_fwd_set;
    logic             r_fwd_clr;

    // Tracker state
    logic [CNT_W-1:0]  r_total;
    logic [DCNT_W-1:0] r_distinct;
    logic [IDX_W-1:0]  r_highest;
    logic [CNT_W-1:0]  n_total;
    logic [DCNT_W-1:0] n_distinct;
    logic [IDX_W-1:0]  n_highest;

    logic b_present;
    logic b_set;
    logic b_clear;

    assign b_clear = (r_b_op == OP_CLEAR);
    assign b_set   = !b_clear && r_b_match;

    // Forward the commit that landed on the same edge as this entry's read.
    always_comb begin
        if (r_fwd_clr) begin
            b_present = 1'b0;
        end else if (r_fwd_set) begin
            b_present = 1'b1;
        end else begin
            b_present = r_vld_rd && r_mem_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && b_set) begin
            r_mem[r_b_idx] <= 1'b1;
        end
        if (b_load) begin
            r_mem_rd <= r_mem[i_in.frag_index];
        end
    end

    // ---------------------------------------------------------------
    // Stage B: commit and completeness
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] c_total;
    logic [CMP_W-1:0] c_distinct;
    logic [CMP_W-1:0] c_highest;
    logic             b_complete;

    always_comb begin
        n_total    = r_total;
        n_distinct = r_distinct;
        n_highest  = r_highest;
        if (b_set) begin
            if (!b_present) begin
                n_distinct = r_distinct + DCNT_W'(1);
            end
            if (r_total != CNT_SAT) begin
                n_total = r_total + CNT_W'(1);
            end
            if (r_b_idx > r_highest) begin
                n_highest = r_b_idx;
            end
        end
    end

    assign c_total    = CMP_W'(n_total);
    assign c_distinct = CMP_W'(n_distinct);
    assign c_highest  = CMP_W'(n_highest);
    assign b_complete = (c_total != '0) && (c_total <= CMP_MAX)
                        && (c_total == c_distinct) && (c_highest < c_total);

    t_out_item b_res;
    logic [CNT_W+OCNT_W-1:0] b_cnt_ext;

    assign b_cnt_ext = {{OCNT_W{1'b0}}, n_total};

    always_comb begin
        if (b_clear) begin
            b_res.status       = ST_CLEARED;
            b_res.computed_crc = '0;
            b_res.stored_count = '0;
            b_res.complete     = 1'b0;
        end else begin
            b_res.status       = r_b_match ? ST_ACCEPT : ST_REJECT;
            b_res.computed_crc = r_b_crc;
            b_res.stored_count = b_cnt_ext[OCNT_W-1:0];
            b_res.complete     = b_complete;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_ONES;
            r_vld       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
            r_distinct  <= '0;
            r_highest   <= '0;
            r_fwd_set   <= 1'b0;
            r_fwd_clr   <= 1'b0;
        end else begin
            r_crc <= n_crc;

            // Advance the check stage
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end

            if (b_load) begin
                r_fwd_set <= b_fire && b_set && (r_b_idx == i_in.frag_index);
                r_fwd_clr <= b_fire && b_clear;
            end

            // Commit the tracker state
            if (b_fire) begin
                if (b_clear) begin
                    r_vld      <= '0;
                    r_total    <= '0;
                    r_distinct <= '0;
                    r_highest  <= '0;
                end else begin
                    if (b_set) begin
                        r_vld[r_b_idx] <= 1'b1;
                    end
                    r_total    <= n_total;
                    r_distinct <= n_distinct;
                    r_highest  <= n_highest;
                end
            end

            // Output register: load on drain, drop when taken
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_op    <= i_in.op;
            r_b_idx   <= i_in.frag_index;
            r_b_crc   <= a_final;
            r_b_match <= (a_final == i_in.given_crc);
            r_vld_rd  <= r_vld[i_in.frag_index];
        end
        if (b_fire) begin
            r_out <= b_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_b_valid && r_out_valid))
        else $error("input stalled with a free check stage");

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && b_clear) |=> (r_total == '0 && r_distinct == '0 && r_vld == '0))
        else $error("tracker state not cleared after clear commit");

    a_cleared_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_CLEARED)
            |-> (o_out.stored_count == '0 && !o_out.complete && o_out.computed_crc == '0))
        else $error("cleared result carries non-zero fields");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && !b_clear && !r_b_match) |=> $stable(r_total))
        else $error("rejected fragment changed the stored count");

    a_end_restarts_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load |=> (r_crc == CRC_ONES))
        else $error("running CRC not restarted at fragment end");

endmodule

// ===== test/tb_fragment_crc_check_tracker_core.sv =====
module tb_fragment_crc_check_tracker_core;
    import fcct_pkg::*;

    // Depth of the tracker under test; the count saturates one above it.
    localparam int unsigned MAX_FRAGMENTS   = 256;
    // Random items after the directed table.
    localparam int unsigned RANDOM_ITEMS    = 1300;
    // Cycles with no item moving on either side before the run is declared hung.
    localparam int unsigned IDLE_LIMIT      = 4000;
    // One long receiver hold-off, started once this many items have gone in.
    localparam int unsigned HOLD_OFF_AFTER  = 400;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    // Margin after the last expected result, before the verdict.
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned REPORT_LIMIT    = 10;

    // One stimulus row: the item, and a typed-in result where one is given.
    typedef struct packed {
        t_in_item  item;
        logic      fixed;
        t_out_item res;
    } t_stim_row;

    // Receiver stall patterns, each held for a random span.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    localparam t_out_item NO_RESULT = '0;

    // Directed table. Typed-in results only where they can be read straight off:
    // the empty fragment (CRC zero), a reject, a duplicate, clears, and the
    // well-known check value of the ASCII string "123456789".
    localparam t_stim_row DIRECTED_ROWS [18] = '{
        // Empty fragment, index 0, correct CRC: stored, tracker complete.
        '{'{OP_EMPTY_END, 8'h00, 8'h00, 32'h0000_0000}, 1'b1,
          '{ST_ACCEPT, 32'h0000_0000, 9'd1, 1'b1}},
        // Empty fragment with a wrong CRC: rejected, state untouched.
        '{'{OP_EMPTY_END, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_REJECT, 32'h0000_0000, 9'd1, 1'b1}},
        // Duplicate index: counted, but no longer complete.
        '{'{OP_EMPTY_END, 8'h00, 8'h00, 32'h0000_0000}, 1'b1,
          '{ST_ACCEPT, 32'h0000_0000, 9'd2, 1'b0}},
        '{'{OP_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
          '{ST_CLEARED, 32'h0000_0000, 9'd0, 1'b0}},
        '{'{OP_DATA, 8'h31, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h32, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h33, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h34, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h35, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h36, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h37, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_DATA, 8'h38, 8'h00, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_LAST, 8'h39, 8'h00, 32'hCBF4_3926}, 1'b1,
          '{ST_ACCEPT, 32'hCBF4_3926, 9'd1, 1'b1}},
        // Extremes of the byte and the index; leave these to the predictor.
        '{'{OP_DATA, 8'h00, 8'hFF, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
        '{'{OP_LAST, 8'hFF, 8'h01, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_LAST, 8'hFF, 8'h80, 32'h5555_AAAA}, 1'b0, NO_RESULT},
        '{'{OP_EMPTY_END, 8'hA5, 8'hFF, 32'h0000_0000}, 1'b0, NO_RESULT},
        '{'{OP_CLEAR, 8'h00, 8'h00, 32'h0000_0000}, 1'b1,
          '{ST_CLEARED, 32'h0000_0000, 9'd0, 1'b0}}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_stim_row   stim_q [$];
    t_out_item   expected_q [$];
    int unsigned items_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // Predictor state: CRC of the fragment in flight and the tracker contents.
    logic [31:0] frag_crc;
    bit          seen_map [MAP_DEPTH];
    int unsigned stored_total;
    int unsigned seen_total;
    int unsigned top_index;

    fragment_crc_check_tracker_core #(
        .MAX_FRAGMENTS(MAX_FRAGMENTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #10 clk = ~clk;

    // Shift one byte through the reflected CRC, a data bit at a time.
    function automatic logic [31:0] crc_advance(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        bit          fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_in_item random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    task automatic reset_tracker();
        frag_crc     = CRC_ONES;
        stored_total = 0;
        seen_total   = 0;
        top_index    = 0;
        foreach (seen_map[i]) begin
            seen_map[i] = 1'b0;
        end
    endtask

    // Advance the tracker by one item and give the result it causes, if any.
    task automatic track_fragment(input t_in_item it, output bit produced,
                                  output t_out_item res);
        logic [31:0] final_crc;
        res      = NO_RESULT;
        produced = 1'b1;
        if (it.op == OP_CLEAR) begin
            reset_tracker();
            res.status = ST_CLEARED;
            return;
        end
        if (it.op == OP_DATA || it.op == OP_LAST) begin
            frag_crc = crc_advance(frag_crc, it.data_byte);
        end
        if (it.op == OP_DATA) begin
            produced = 1'b0;
            return;
        end
        // Fragment end: invert, and rearm the CRC whatever the outcome.
        final_crc        = ~frag_crc;
        frag_crc         = CRC_ONES;
        res.computed_crc = final_crc;
        if (final_crc == it.given_crc) begin
            res.status = ST_ACCEPT;
            if (!seen_map[it.frag_index]) begin
                seen_map[it.frag_index] = 1'b1;
                seen_total++;
            end
            if (stored_total < MAX_FRAGMENTS + 1) begin
                stored_total++;
            end
            if (it.frag_index > top_index) begin
                top_index = it.frag_index;
            end
        end else begin
            res.status = ST_REJECT;
        end
        res.stored_count = stored_total[OCNT_W-1:0];
        // Complete: every index below the count seen exactly once, no overflow.
        res.complete = (stored_total != 0) && (stored_total <= MAX_FRAGMENTS) &&
                       (stored_total == seen_total) && (top_index < stored_total);
    endtask

    task automatic push_random(input t_in_item it);
        stim_q.push_back(t_stim_row'{item: it, fixed: 1'b0, res: NO_RESULT});
    endtask

    // Random part: mostly well-formed fragments with correct CRCs and indices that
    // climb from zero, so that the tracker reaches completeness between clears;
    // the rest is bad CRCs, stray indices, clears and raw noise.
    task automatic build_random();
        t_in_item    it;
        logic [31:0] crc;
        logic [7:0]  next_idx;
        int unsigned made;
        int unsigned nbytes;
        int unsigned pick;
        bit          overflow_done;
        made          = 0;
        next_idx      = '0;
        overflow_done = 1'b0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (!overflow_done && made >= RANDOM_ITEMS / 2) begin
                // Clear, then store more empty fragments than the map holds: the
                // count passes through a full, complete map and then saturates.
                it    = random_item();
                it.op = OP_CLEAR;
                push_random(it);
                for (int k = 0; k < MAX_FRAGMENTS + 4; k++) begin
                    it            = random_item();
                    it.op         = OP_EMPTY_END;
                    it.frag_index = 8'(255 - k);
                    it.given_crc  = '0;
                    push_random(it);
                end
                made          += MAX_FRAGMENTS + 5;
                overflow_done  = 1'b1;
                next_idx       = '0;
            end else if (pick < 4) begin
                it    = random_item();
                it.op = OP_CLEAR;
                push_random(it);
                next_idx = '0;
                made++;
            end else if (pick < 14) begin
                push_random(random_item());
                made++;
            end else begin
                nbytes = $urandom_range(0, 6);
                crc    = CRC_ONES;
                for (int j = 0; j < nbytes; j++) begin
                    it = random_item();
                    if (j == nbytes - 1) begin
                        it.op = OP_LAST;
                    end else begin
                        it.op = OP_DATA;
                    end
                    crc = crc_advance(crc, it.data_byte);
                    if (j != nbytes - 1) begin
                        push_random(it);
                    end
                end
                if (nbytes == 0) begin
                    it    = random_item();
                    it.op = OP_EMPTY_END;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    it.frag_index = next_idx;
                end else if (pick < 85) begin
                    it.frag_index = 8'($urandom_range(0, next_idx));
                end else begin
                    it.frag_index = 8'($urandom_range(0, 255));
                end
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    it.given_crc = ~crc;
                    if (it.frag_index == next_idx) begin
                        next_idx++;
                    end
                end else if (pick < 93) begin
                    it.given_crc = ~crc ^ (32'd1 << $urandom_range(0, 31));
                end else begin
                    it.given_crc = $urandom;
                end
                push_random(it);
                made += (nbytes == 0) ? 1 : nbytes;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s: expected status %0d crc %08h count %0d complete %0d,",
                     what, want.status, want.computed_crc, want.stored_count,
                     want.complete);
            $display("    got status %0d crc %08h count %0d complete %0d",
                     got.status, got.computed_crc, got.stored_count, got.complete);
        end
    endtask

    // Sender: walk the stimulus in bursts with random gaps, holding each item
    // until it is taken; then drain and give the verdict.
    initial begin : sender
        int unsigned burst_left;
        int unsigned gap;
        reset_tracker();
        foreach (DIRECTED_ROWS[i]) begin
            stim_q.push_back(DIRECTED_ROWS[i]);
        end
        build_random();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = 0;
        foreach (stim_q[n]) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    // Drop valid and scramble the idle payload.
                    in_valid <= 1'b0;
                    in_item  <= random_item();
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            in_item  <= stim_q[n].item;
            do @(posedge clk); while (in_stall);
        end
        in_valid <= 1'b0;
        // Let the last acceptance reach the predictor, then wait out the results.
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: switch between stall patterns, and once hold off long enough
    // that the block fills and stalls its input.
    initial begin : receiver
        t_stall_mode mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && items_taken >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(8, 60);
                repeat (span) begin
                    case (mode)
                        STALL_NONE:  out_stall <= 1'b0;
                        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
                        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                        default:     out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Input side: predict every item the block takes; a typed-in result in the
    // table takes the place of the predicted one.
    always @(posedge clk) begin : take_item
        bit        produced;
        t_out_item res;
        if (rst_n && in_valid && !in_stall) begin
            track_fragment(in_item, produced, res);
            if (produced) begin
                if (stim_q[items_taken].fixed) begin
                    expected_q.push_back(stim_q[items_taken].res);
                end else begin
                    expected_q.push_back(res);
                end
            end
            items_taken++;
        end
    end

    // Output side: match each result against the oldest expectation.
    always @(posedge clk) begin : check_result
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with none expected", NO_RESULT, out_item);
            end else begin
                want = expected_q.pop_front();
                if (want.status != out_item.status ||
                    want.computed_crc != out_item.computed_crc ||
                    want.stored_count != out_item.stored_count ||
                    want.complete != out_item.complete) begin
                    report_mismatch("result mismatch", want, out_item);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
